/* design/slfr_pkg.sv */
// ----------------------------------------------------------------------------
// slfr_pkg: shared types and constants of the sync/length frame receiver
// Holds the word that passes from the parser to the CRC stage, the CRC
// constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam logic [7:0]  SYNC_RESET = 8'hAA;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam int unsigned POS_W = 9;

  // One classified word on its way from the parser to the CRC stage.
  // Data and position are already zero for words that are not stored.
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             stored;
    logic             last;
  } slfr_item_t;

  // Reflected CRC-16 over one byte, one bit per step.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/slfr_front.sv */
// ----------------------------------------------------------------------------
// slfr_front: frame parser
// Hunts for the sync pair, counts header, payload and CRC bytes and tags each
// accepted word with its position, stored flag and frame end flag.
// ----------------------------------------------------------------------------
module slfr_front
  import slfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       sync_value,
  input  logic             accept,
  input  logic             func,
  input  logic [7:0]       data_byte,
  output slfr_item_t       item
);

  localparam logic [3:0] STEP_SYNC1    = 4'd0;
  localparam logic [3:0] STEP_SYNC2    = 4'd1;
  localparam logic [3:0] STEP_HDR_FIRST = 4'd2;
  localparam logic [3:0] STEP_LENGTH   = 4'd6;
  localparam logic [3:0] STEP_HDR_LAST = 4'd11;
  localparam logic [3:0] STEP_PAYLOAD  = 4'd12;
  localparam logic [3:0] STEP_CRC_LAST = 4'd13;

  logic [3:0]       step_r, step_nxt;
  logic [7:0]       remain_r, remain_nxt;
  logic [POS_W-1:0] wpos_r, wpos_nxt;
  logic             stored;
  logic             last;

  always_comb begin
    step_nxt   = step_r;
    remain_nxt = remain_r;
    stored     = 1'b0;
    last       = 1'b0;
    if (func) begin
      step_nxt   = STEP_SYNC1;
      remain_nxt = 8'd0;
    end else begin
      unique case (step_r) inside
        STEP_SYNC1: begin
          if (data_byte == sync_value) step_nxt = STEP_SYNC2;
        end
        STEP_SYNC2: begin
          step_nxt = (data_byte == sync_value) ? STEP_HDR_FIRST : STEP_SYNC1;
        end
        [STEP_HDR_FIRST:STEP_HDR_LAST]: begin
          stored   = 1'b1;
          step_nxt = step_r + 4'd1;
          if (step_r == STEP_LENGTH) remain_nxt = data_byte;
        end
        STEP_PAYLOAD: begin
          stored = 1'b1;
          if (remain_r != 8'd0) remain_nxt = remain_r - 8'd1;
          else                  step_nxt   = STEP_CRC_LAST;
        end
        STEP_CRC_LAST: begin
          stored     = 1'b1;
          last       = 1'b1;
          step_nxt   = STEP_SYNC1;
          remain_nxt = 8'd0;
        end
        default: begin
          step_nxt   = STEP_SYNC1;
          remain_nxt = 8'd0;
        end
      endcase
    end
    // Position restarts whenever the parser falls back to hunting.
    if (step_nxt == STEP_SYNC1 || step_nxt == STEP_SYNC2) wpos_nxt = '0;
    else if (stored)                                       wpos_nxt = wpos_r + 9'd1;
    else                                                   wpos_nxt = wpos_r;
  end

  assign item.data   = stored ? data_byte : 8'd0;
  assign item.pos    = stored ? wpos_r : '0;
  assign item.stored = stored;
  assign item.last   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_SYNC1;
      remain_r <= 8'd0;
      wpos_r   <= '0;
    end else if (accept) begin
      step_r   <= step_nxt;
      remain_r <= remain_nxt;
      wpos_r   <= wpos_nxt;
    end
  end

  // A completed frame always sends the parser back to hunting.
  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.last |=> step_r == STEP_SYNC1 && wpos_r == '0)
    else $error("parser did not rearm after frame end");

  // A timeout always sends the parser back to hunting.
  a_timeout_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func |=> step_r == STEP_SYNC1 && remain_r == 8'd0)
    else $error("parser did not rearm after timeout");

endmodule

/* design/slfr_fifo.sv */
// ----------------------------------------------------------------------------
// slfr_fifo: queue between parser and CRC stage
// A small register queue of classified words.
// ----------------------------------------------------------------------------
module slfr_fifo
  import slfr_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  slfr_item_t wr_item,
  input  logic       rd_en,
  output slfr_item_t rd_item,
  output logic       not_empty,
  output logic       full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  slfr_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == CNT_FULL;
  assign rd_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
      if (rd_en) rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
      if (wr_en && !rd_en)      cnt_r <= cnt_r + CNT_W'(1);
      else if (rd_en && !wr_en) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(wr_en && !rd_en))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !rd_en)
    else $error("queue read while empty");

endmodule

/* design/slfr_back.sv */
// ----------------------------------------------------------------------------
// slfr_back: CRC stage and result register
// Runs the CRC over stored words, judges the residue at frame end and holds
// the result word until it is popped.
// ----------------------------------------------------------------------------
module slfr_back
  import slfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  slfr_item_t       q_item,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       byte_out,
  output logic [POS_W-1:0] byte_position,
  output logic             byte_stored,
  output logic             frame_end,
  output logic             frame_ok
);

  logic             valid_r;
  logic [15:0]      crc_r, crc_base, crc_new;
  logic [7:0]       data_r;
  logic [POS_W-1:0] pos_r;
  logic             stored_r, end_r, ok_r;

  // The first stored word of a frame always sits at position zero, so the
  // CRC restarts there.
  assign crc_base = (q_item.pos == '0) ? CRC_INIT : crc_r;
  assign crc_new  = q_item.stored ? crc16_byte(crc_base, q_item.data) : crc_r;
  assign q_rd     = q_not_empty && (!valid_r || pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      crc_r   <= CRC_INIT;
    end else begin
      if (q_rd)      valid_r <= 1'b1;
      else if (pop)  valid_r <= 1'b0;
      if (q_rd)      crc_r   <= q_item.last ? CRC_INIT : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      data_r   <= q_item.data;
      pos_r    <= q_item.pos;
      stored_r <= q_item.stored;
      end_r    <= q_item.last;
      ok_r     <= q_item.last && (crc_new == 16'h0000);
    end
  end

  assign empty         = !valid_r;
  assign byte_out      = data_r;
  assign byte_position = pos_r;
  assign byte_stored   = stored_r;
  assign frame_end     = end_r;
  assign frame_ok      = ok_r;

  a_ok_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && ok_r |-> end_r)
    else $error("frame good flagged without frame end");

  a_end_needs_stored: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && end_r |-> stored_r)
    else $error("frame end on a word that was not stored");

endmodule

/* design/sync_length_frame_receiver_crc16.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_crc16: length-prefixed frame receiver
// Parses sync pair, header, payload and CRC bytes and checks a CRC-16.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle in and out, sustained, while pop keeps up.
// A pushed word is registered first in the parser queue, then in the result
//   register, before it shows on the result ports.
// The CRC stage runs one byte-wide CRC-16 update per cycle while it takes words from the queue; that sets the rate.
// Reset (rst_n low, synchronous): parser hunts for the first sync byte, queue
//   and result register are empty, sync value returns to 0xAA.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_crc16
  import slfr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration: the sync value register.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // Input words.
  input  logic       push,
  output logic       full,
  input  logic       in_func,
  input  logic [7:0] in_data_byte,
  // Result words.
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_out,
  output logic [8:0] out_byte_position,
  output logic       out_byte_stored,
  output logic       out_frame_end,
  output logic       out_frame_ok
);

  logic [7:0] sync_r;
  logic       in_accept;
  slfr_item_t front_item;
  slfr_item_t q_item;
  logic       q_not_empty;
  logic       q_full;
  logic       q_rd;

  // The register may be written at any time; a write is taken whenever cfg_valid is high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
    end else if (cfg_valid) begin
      sync_r <= cfg_data;
    end
  end

  // Every accepted word produces exactly one result word, so the queue full
  // flag is the only thing that holds off the sender.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  // Front: the parser classifies each word as it arrives.
  slfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .sync_value (sync_r),
    .accept     (in_accept),
    .func       (in_func),
    .data_byte  (in_data_byte),
    .item       (front_item)
  );

  // Queue between parser and CRC stage so that each side can stall alone.
  slfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_accept),
    .wr_item   (front_item),
    .rd_en     (q_rd),
    .rd_item   (q_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: CRC accumulation, residue check and the result register.
  slfr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_item        (q_item),
    .q_rd          (q_rd),
    .pop           (pop),
    .empty         (empty),
    .byte_out      (out_byte_out),
    .byte_position (out_byte_position),
    .byte_stored   (out_byte_stored),
    .frame_end     (out_frame_end),
    .frame_ok      (out_frame_ok)
  );

  // A result word that is not popped must hold still.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte_out) && $stable(out_frame_ok))
    else $error("result word changed before it was popped");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sync/length frame receiver with CRC-16 check
// Drives serial words and line timeouts into the receiver and predicts every
// result word. The sync value register is written between phases while the
// block is idle, and the sender and receiver idle at random.
// ----------------------------------------------------------------------------
module testbench
  import slfr_pkg::*;
();

  // Word kinds on the input channel.
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // Parser steps, counted from the first sync byte.
  localparam logic [3:0] STEP_SYNC1     = 4'd0;
  localparam logic [3:0] STEP_SYNC2     = 4'd1;
  localparam logic [3:0] STEP_HDR_FIRST = 4'd2;
  localparam logic [3:0] STEP_LEN       = 4'd6;
  localparam logic [3:0] STEP_HDR_LAST  = 4'd11;
  localparam logic [3:0] STEP_BODY      = 4'd12;
  localparam logic [3:0] STEP_CRC_HI    = 4'd13;

  localparam int HDR_BYTES     = 10;
  localparam int LEN_IN_HDR    = 4;
  localparam int DRAIN_CYCLES  = 4;
  localparam int STALL_LIMIT   = 4000;

  // One expected result word.
  typedef struct packed {
    logic [7:0] data;
    logic [8:0] pos;
    logic       stored;
    logic       fend;
    logic       fok;
  } rx_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       push = 1'b0;
  logic       full;
  logic       in_func = FUNC_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_out;
  logic [8:0] out_byte_position;
  logic       out_byte_stored;
  logic       out_frame_end;
  logic       out_frame_ok;

  // Predictor state: a private copy of the parser and the sync register.
  logic [7:0]  sync_val;
  logic [3:0]  parse_state;
  logic [7:0]  payload_left;
  logic [15:0] crc_acc;
  logic [8:0]  write_pos;

  rx_word_t expected_words[$];
  rx_word_t head_word;

  int words_sent = 0;
  int words_checked = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int fail_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  sync_length_frame_receiver_crc16 u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte_out      (out_byte_out),
    .out_byte_position (out_byte_position),
    .out_byte_stored   (out_byte_stored),
    .out_frame_end     (out_frame_end),
    .out_frame_ok      (out_frame_ok)
  );

  always #5 clk = ~clk;

  // Reflected CRC-16, fed one data bit at a time: the feedback bit is the
  // register's low bit combined with the incoming data bit.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[15:1]} ^ ((r[0] ^ d[k]) ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Back to hunting for the first sync byte with a fresh CRC.
  function automatic void rearm_parser();
    parse_state  = STEP_SYNC1;
    payload_left = 8'd0;
    crc_acc      = CRC_INIT;
    write_pos    = 9'd0;
  endfunction

  // Advances the parser copy by one accepted word and returns the result
  // word that the block must produce for it.
  function automatic rx_word_t frame_parser_predict(input logic f, input logic [7:0] d);
    rx_word_t w;
    logic     keep;
    logic     last;
    w    = '0;
    keep = 1'b0;
    last = 1'b0;
    if (f == FUNC_TIMEOUT) begin
      rearm_parser();
    end else begin
      case (parse_state)
        STEP_SYNC1: begin
          if (d == sync_val) parse_state = STEP_SYNC2;
        end
        STEP_SYNC2: begin
          // A wrong second byte is dropped; it does not count as a new first sync.
          if (d == sync_val) parse_state = STEP_HDR_FIRST;
          else rearm_parser();
        end
        STEP_BODY: begin
          keep = 1'b1;
          if (payload_left != 8'd0) payload_left = payload_left - 8'd1;
          else parse_state = STEP_CRC_HI;
        end
        STEP_CRC_HI: begin
          keep = 1'b1;
          last = 1'b1;
        end
        default: begin
          if (parse_state <= STEP_HDR_LAST) begin
            keep = 1'b1;
            if (parse_state == STEP_LEN) payload_left = d;
            parse_state = parse_state + 4'd1;
          end else begin
            // Steps past the second CRC byte do not exist; rearm.
            rearm_parser();
          end
        end
      endcase
    end
    if (keep) begin
      w.data    = d;
      w.pos     = write_pos;
      w.stored  = 1'b1;
      crc_acc   = crc16_step(crc_acc, d);
      write_pos = write_pos + 9'd1;
    end
    if (last) begin
      w.fend = 1'b1;
      w.fok  = (crc_acc == 16'h0000);
      rearm_parser();
    end
    return w;
  endfunction

  // Sends one word. Push stays high after acceptance unless the sender idles,
  // so back-to-back words go out on consecutive edges while full stays low.
  task automatic send_word(input logic f, input logic [7:0] d);
    in_func      <= f;
    in_data_byte <= d;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_words.push_back(frame_parser_predict(f, d));
    words_sent++;
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Sends a sync pair, a header carrying pay_len, the payload and the CRC.
  // With corrupt set one bit of the frame body is flipped. A cut_at of zero
  // or more, under the body size, stops there and then sends a line timeout.
  task automatic send_frame(input int pay_len, input bit corrupt, input int cut_at);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          n;
    int          hit;
    crc = CRC_INIT;
    for (int i = 0; i < HDR_BYTES + pay_len; i++) begin
      if (i == LEN_IN_HDR) body.push_back(pay_len[7:0]);
      else body.push_back(8'($urandom));
      crc = crc16_step(crc, body[i]);
    end
    // Low CRC byte first, so a clean frame leaves a zero residue.
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (corrupt) begin
      hit = $urandom_range(body.size() - 1);
      body[hit] = body[hit] ^ (8'h01 << $urandom_range(7));
    end
    n = (cut_at >= 0 && cut_at < body.size()) ? cut_at : body.size();
    send_word(FUNC_BYTE, sync_val);
    send_word(FUNC_BYTE, sync_val);
    for (int i = 0; i < n; i++) send_word(FUNC_BYTE, body[i]);
    if (n != body.size()) send_word(FUNC_TIMEOUT, 8'($urandom));
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the sync value register once the block is idle.
  task automatic set_sync_value(input logic [7:0] v);
    drain_results();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sync_val = v;
  endtask

  // Bytes outside a frame, a rejected second sync and the start of a frame.
  task automatic test_sync_hunt();
    send_word(FUNC_BYTE, 8'h00);
    send_word(FUNC_BYTE, 8'hFF);
    send_word(FUNC_BYTE, sync_val);
    send_word(FUNC_BYTE, ~sync_val);
    send_word(FUNC_BYTE, sync_val);
    send_word(FUNC_BYTE, sync_val);
    send_word(FUNC_BYTE, sync_val);
    send_word(FUNC_TIMEOUT, 8'hFF);
  endtask

  // Line timeouts while hunting, between the syncs, in the header, after the
  // payload and just before the second CRC byte.
  task automatic test_timeouts();
    send_word(FUNC_TIMEOUT, 8'h00);
    send_word(FUNC_BYTE, sync_val);
    send_word(FUNC_TIMEOUT, sync_val);
    send_frame(2, 1'b0, 4);
    send_frame(1, 1'b0, 11);
    send_frame(0, 1'b0, 11);
  endtask

  // Zero-length payload, a damaged frame and a short clean frame.
  task automatic test_short_frames();
    send_frame(0, 1'b0, -1);
    send_frame(1, 1'b1, -1);
    send_frame(2, 1'b0, -1);
  endtask

  // The largest payload reaches the last byte position.
  task automatic test_longest_frame();
    send_frame(255, 1'b0, -1);
  endtask

  // Mostly clean frames with random content; the rest are damaged frames,
  // cut frames, stray bytes and stray timeouts.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int n_words);
    int start;
    int pick;
    int len;
    start     = words_sent;
    gap_pct   = sender_idle;
    stall_pct = receiver_stall;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6);
      if (pick < 65) begin
        send_frame(len, 1'b0, -1);
      end else if (pick < 78) begin
        send_frame(len, 1'b1, -1);
      end else if (pick < 88) begin
        send_frame(len, 1'b0, $urandom_range(HDR_BYTES + len + 1));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(FUNC_BYTE, ($urandom_range(3) == 0) ? sync_val : 8'($urandom));
        end
        // Usually clear out whatever the stray bytes started.
        if ($urandom_range(4) != 0) send_word(FUNC_TIMEOUT, 8'($urandom));
      end else begin
        send_word(FUNC_TIMEOUT, 8'($urandom));
      end
    end
  endtask

  // Compares one field of the result word with its expectation.
  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result checker: every accepted result word is matched against the oldest
  // expectation. The pop for the next edge is drawn here as well.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: byte_out %0h position %0h",
               out_byte_out, out_byte_position);
        fail_count++;
      end else begin
        head_word = expected_words.pop_front();
        check_field("byte_out", 9'(head_word.data), 9'(out_byte_out));
        check_field("byte_position", head_word.pos, out_byte_position);
        check_field("byte_stored", 9'(head_word.stored), 9'(out_byte_stored));
        check_field("frame_end", 9'(head_word.fend), 9'(out_frame_end));
        check_field("frame_ok", 9'(head_word.fok), 9'(out_frame_ok));
        if (head_word.fend) begin
          if (head_word.fok) good_frames++;
          else bad_frames++;
        end
        words_checked++;
      end
    end
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sync_val = SYNC_RESET;
    rearm_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the sync value left at its reset value.
    test_sync_hunt();
    test_timeouts();
    test_short_frames();

    // Lowest sync value, with the longest possible frame.
    set_sync_value(8'h00);
    test_longest_frame();

    // Random phases, each under its own sync value and idling pattern.
    set_sync_value(8'hFF);
    test_random_traffic(0, 0, 35);
    set_sync_value(8'($urandom));
    test_random_traffic(76, 0, 35);
    set_sync_value(8'h00);
    test_random_traffic(0, 76, 35);
    set_sync_value(SYNC_RESET);
    test_random_traffic(22, 22, 35);

    drain_results();
    $display("Sent %0d input words and checked %0d result words across four idling phases.",
             words_sent, words_checked);
    $display("Frame ends seen: %0d with good CRC, %0d with bad CRC;", good_frames, bad_frames);
    $display("sync values 0xAA, 0x00, 0xFF and one random were used.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/slfr_pkg.sv
design/slfr_front.sv
design/slfr_fifo.sv
design/slfr_back.sv
design/sync_length_frame_receiver_crc16.sv
tb/testbench.sv
